### hw/rtl/lcs_pkg.sv
package lcs_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EUC,      // quotient bits of r0 / r1, q * s1 accumulated alongside
    ST_EUC_UPD,  // remainder and Bezout coefficient rotate
    ST_RHS_DIV,  // rhs / gcd
    ST_RHS_CHK,
    ST_MOD_DIV,  // modulus / gcd
    ST_MOD_CHK,
    ST_V_DIV,    // (rhs / gcd) mod m
    ST_MUL_SET,
    ST_MUL       // (u * v) mod m, shift and add
  } state_t;

endpackage

### hw/rtl/linear_congruence_solver.sv
// Solves coef * x = rhs (mod modulus) for the least non-negative x modulo
// modulus / gcd(coef, modulus); out_solvable is 0 (with out_solution 0) when
// the gcd does not divide rhs or the modulus is zero. A request is taken when
// start is high and busy is low; busy then stays high until the result
// strobe, but a zero modulus is answered without busy going high. The
// result is presented for exactly one cycle on out_valid and must be
// captured then: there is no way to hold it off. All divisions run on one
// restoring divider that retires one quotient bit per cycle; the same
// registers then serve a bit-serial modular multiplier. Every Euclid step is
// a divide of MOD_WIDTH quotient bits followed by an update (ST_EUC_UPD),
// and the number of Euclid steps is at most about 1.44 * MOD_WIDTH + 2. A
// zero modulus or an unsolvable request finishes early.
module linear_congruence_solver #(
  parameter int MOD_WIDTH = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [MOD_WIDTH-1:0] in_coef,
  input  logic [MOD_WIDTH-1:0] in_rhs,
  input  logic [MOD_WIDTH-1:0] in_modulus,
  output logic                 out_valid,
  output logic [MOD_WIDTH-1:0] out_solution,
  output logic                 out_solvable
);

  localparam int W  = MOD_WIDTH;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  lcs_pkg::state_t state_r, state_nxt;

  // shared divider: dividend shifts out MSB first, remainder builds up
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Bezout coefficients of coef; |s| <= modulus / gcd, |q * s1| <= 2 * modulus
  logic signed [W+1:0] s0_r, s0_nxt;
  logic signed [W+1:0] s1_r, s1_nxt;
  logic signed [W+1:0] acc_r, acc_nxt;

  logic [W-1:0] rhs_r, rhs_nxt;
  logic [W-1:0] mod_r, mod_nxt;
  logic [W-1:0] rq_r, rq_nxt;   // rhs / gcd
  logic [W-1:0] m_r, m_nxt;     // modulus / gcd
  logic [W:0]   u_r, u_nxt;     // s0 brought into [0, m]

  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_solution_r, out_solution_nxt;
  logic         out_solvable_r, out_solvable_nxt;

  logic [W:0]   div_cur, div_sub;
  logic         div_ge;
  logic [W-1:0] div_rem;
  logic [W-1:0] div_quo;
  logic         cnt_last;
  logic signed [W+1:0] acc_step;
  logic signed [W+1:0] s_new;
  logic signed [W+1:0] u_wide;

  logic [W:0]   mul_dbl, mul_dbl_red, mul_sum, mul_sum_red;

  logic         req;

  assign req      = start && (state_r == lcs_pkg::ST_IDLE);
  assign cnt_last = (cnt_r == '0);

  // one restoring divide step
  always_comb begin
    div_cur = {rem_r, dvd_r[W-1]};
    div_sub = div_cur - {1'b0, dsr_r};
    div_ge  = (div_cur >= {1'b0, dsr_r});
    div_rem = div_ge ? div_sub[W-1:0] : div_cur[W-1:0];
    div_quo = {quo_r[W-2:0], div_ge};
  end

  // Horner form of q * s1: prefix of the quotient times s1
  assign acc_step = (acc_r <<< 1) + (div_ge ? s1_r : '0);
  assign s_new    = s0_r - acc_r;
  assign u_wide   = s0_r + (s0_r[W+1] ? $signed({2'b00, quo_r}) : '0);

  // one bit of (u * v) mod m, v taken MSB first from the dividend register
  always_comb begin
    mul_dbl     = {rem_r, 1'b0};
    mul_dbl_red = (mul_dbl >= {1'b0, m_r}) ? mul_dbl - {1'b0, m_r} : mul_dbl;
    mul_sum     = {1'b0, mul_dbl_red[W-1:0]} + (dvd_r[W-1] ? {1'b0, u_r[W-1:0]} : '0);
    mul_sum_red = (mul_sum >= {1'b0, m_r}) ? mul_sum - {1'b0, m_r} : mul_sum;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcs_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (in_modulus == '0) ? lcs_pkg::ST_IDLE : lcs_pkg::ST_EUC;
        end
      end
      lcs_pkg::ST_EUC: begin
        if (cnt_last) state_nxt = lcs_pkg::ST_EUC_UPD;
      end
      lcs_pkg::ST_EUC_UPD: begin
        state_nxt = (rem_r == '0) ? lcs_pkg::ST_RHS_DIV : lcs_pkg::ST_EUC;
      end
      lcs_pkg::ST_RHS_DIV: begin
        if (cnt_last) state_nxt = lcs_pkg::ST_RHS_CHK;
      end
      lcs_pkg::ST_RHS_CHK: begin
        state_nxt = (rem_r != '0) ? lcs_pkg::ST_IDLE : lcs_pkg::ST_MOD_DIV;
      end
      lcs_pkg::ST_MOD_DIV: begin
        if (cnt_last) state_nxt = lcs_pkg::ST_MOD_CHK;
      end
      lcs_pkg::ST_MOD_CHK: state_nxt = lcs_pkg::ST_V_DIV;
      lcs_pkg::ST_V_DIV: begin
        if (cnt_last) state_nxt = lcs_pkg::ST_MUL_SET;
      end
      lcs_pkg::ST_MUL_SET: state_nxt = lcs_pkg::ST_MUL;
      lcs_pkg::ST_MUL: begin
        if (cnt_last) state_nxt = lcs_pkg::ST_IDLE;
      end
      default: state_nxt = lcs_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    dvd_nxt          = dvd_r;
    dsr_nxt          = dsr_r;
    rem_nxt          = rem_r;
    quo_nxt          = quo_r;
    cnt_nxt          = cnt_r;
    s0_nxt           = s0_r;
    s1_nxt           = s1_r;
    acc_nxt          = acc_r;
    rhs_nxt          = rhs_r;
    mod_nxt          = mod_r;
    rq_nxt           = rq_r;
    m_nxt            = m_r;
    u_nxt            = u_r;
    out_valid_nxt    = 1'b0;
    out_solution_nxt = out_solution_r;
    out_solvable_nxt = out_solvable_r;

    unique case (state_r)
      lcs_pkg::ST_IDLE: begin
        if (req) begin
          rhs_nxt = in_rhs;
          mod_nxt = in_modulus;
          s0_nxt  = (W+2)'(1);
          s1_nxt  = '0;
          dvd_nxt = in_coef;
          dsr_nxt = in_modulus;
          rem_nxt = '0;
          quo_nxt = '0;
          acc_nxt = '0;
          cnt_nxt = CNT_LAST;
          if (in_modulus == '0) begin
            out_valid_nxt    = 1'b1;
            out_solution_nxt = '0;
            out_solvable_nxt = 1'b0;
          end
        end
      end
      lcs_pkg::ST_EUC: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        acc_nxt = acc_step;
        dvd_nxt = {dvd_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
      end
      lcs_pkg::ST_EUC_UPD: begin
        s0_nxt  = s1_r;
        s1_nxt  = s_new;
        // next dividend is the old divisor, or rhs once the divisor holds the gcd
        dvd_nxt = (rem_r == '0) ? rhs_r : dsr_r;
        dsr_nxt = (rem_r == '0) ? dsr_r : rem_r;
        rem_nxt = '0;
        quo_nxt = '0;
        acc_nxt = '0;
        cnt_nxt = CNT_LAST;
      end
      lcs_pkg::ST_RHS_DIV, lcs_pkg::ST_MOD_DIV, lcs_pkg::ST_V_DIV: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        dvd_nxt = {dvd_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
      end
      lcs_pkg::ST_RHS_CHK: begin
        if (rem_r != '0) begin
          out_valid_nxt    = 1'b1;
          out_solution_nxt = '0;
          out_solvable_nxt = 1'b0;
        end
        rq_nxt  = quo_r;
        dvd_nxt = mod_r;     // divisor still holds the gcd
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = CNT_LAST;
      end
      lcs_pkg::ST_MOD_CHK: begin
        m_nxt   = quo_r;
        u_nxt   = u_wide[W:0];
        dvd_nxt = rq_r;
        dsr_nxt = quo_r;
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = CNT_LAST;
      end
      lcs_pkg::ST_MUL_SET: begin
        u_nxt   = (u_r >= {1'b0, m_r}) ? u_r - {1'b0, m_r} : u_r;
        dvd_nxt = rem_r;     // v = (rhs / gcd) mod m
        rem_nxt = '0;
        cnt_nxt = CNT_LAST;
      end
      lcs_pkg::ST_MUL: begin
        rem_nxt = mul_sum_red[W-1:0];
        dvd_nxt = {dvd_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_last) begin
          out_valid_nxt    = 1'b1;
          out_solution_nxt = mul_sum_red[W-1:0];
          out_solvable_nxt = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r          <= dvd_nxt;
    dsr_r          <= dsr_nxt;
    rem_r          <= rem_nxt;
    quo_r          <= quo_nxt;
    cnt_r          <= cnt_nxt;
    s0_r           <= s0_nxt;
    s1_r           <= s1_nxt;
    acc_r          <= acc_nxt;
    rhs_r          <= rhs_nxt;
    mod_r          <= mod_nxt;
    rq_r           <= rq_nxt;
    m_r            <= m_nxt;
    u_r            <= u_nxt;
    out_solution_r <= out_solution_nxt;
    out_solvable_r <= out_solvable_nxt;
  end

  assign busy         = (state_r != lcs_pkg::ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_solution = out_solution_r;
  assign out_solvable = out_solvable_r;

endmodule
